// ===== src/periodic_timer_bank_top_assert.svh =====
// Assertion macros for the timer bank checker.
// Needs nothing else; included by the checker file.
`ifndef PERIODIC_TIMER_BANK_TOP_ASSERT_SVH
`define PERIODIC_TIMER_BANK_TOP_ASSERT_SVH

// Same-cycle implication, reported with $error
`define PTB_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer bank assertion failed");

// Next-cycle implication, reported with $error
`define PTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer bank assertion failed");

`endif

// ===== src/ptb_pkg.sv =====
// Shared types and codes for the periodic timer bank.
// No dependencies; imported by every module of the block.
package ptb_pkg;

   localparam int SLOTS_DEFAULT = 8;

   // Operation codes
   localparam logic [2:0] OP_TICK         = 3'd0;
   localparam logic [2:0] OP_REGISTER     = 3'd1;
   localparam logic [2:0] OP_REMOVE       = 3'd2;
   localparam logic [2:0] OP_ENABLE       = 3'd3;
   localparam logic [2:0] OP_DISABLE      = 3'd4;
   localparam logic [2:0] OP_SET_INTERVAL = 3'd5;
   localparam logic [2:0] OP_RESTART      = 3'd6;
   localparam logic [2:0] OP_UNUSED       = 3'd7;

   // Status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [2:0]  slot;
      logic [31:0] period;
      logic [31:0] start_time;
      logic        start_enabled;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [2:0] result_slot;
      logic       fired;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic walk_adv;
      logic flush_push;
      logic exec;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic walk_done;
      logic walk_stall;
      logic out_free;
      logic pend_valid;
   } stat_type;

endpackage

// ===== src/ptb_ctrl.sv =====
// Controller state machine of the timer bank.
// Uses ptb_pkg; drives commands into ptb_datapath.
module ptb_ctrl
   import ptb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_op,
   output logic       req_stall,
   input  stat_type   stat,
   output cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_WALK  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;
   localparam logic [1:0] S_EXEC  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Take a new word only when idle
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_op == OP_TICK) begin
                  state_in = S_WALK;
               end else if (req_op == OP_UNUSED) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_WALK: begin
            cmd.walk_adv = !stat.walk_stall;
            if (stat.walk_done) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!stat.pend_valid) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.flush_push = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/ptb_datapath.sv =====
// Datapath of the timer bank: slot flags, period and last-fire memories,
// tick walk pipeline, pending fired word and output register. Uses ptb_pkg.
module ptb_datapath
   import ptb_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int UW = $clog2(SLOTS + 1);
   localparam logic [UW-1:0] USED_MAX = UW'(SLOTS);

   req_type          req_ff;
   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] active_ff;
   logic [UW-1:0]    used_ff;
   logic [31:0]      period_mem_ff [SLOTS];
   logic [31:0]      last_mem_ff [SLOTS];
   logic [31:0]      period_q_ff;
   logic [31:0]      last_q_ff;
   logic [UW-1:0]    rd_idx_ff;
   logic             ev_valid_ff;
   logic [IW-1:0]    ev_idx_ff;
   logic             pend_valid_ff;
   logic             pend_valid_in;
   logic [2:0]       pend_slot_ff;
   logic [2:0]       pend_slot_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic [IW-1:0] slot_idx;
   logic [IW-1:0] new_idx;
   logic [IW-1:0] rd_addr;
   logic          slot_found;
   logic          is_full;
   logic          rd_issue;
   logic          due;
   logic          out_free;
   logic          fire;
   logic          reg_ok;
   logic          per_we;
   logic [IW-1:0] per_addr;
   logic          last_we;
   logic [IW-1:0] last_addr;
   logic [31:0]   last_data;
   logic          load;

   // Decode the held request
   assign slot_idx   = IW'(req_ff.slot);
   assign new_idx    = IW'(used_ff);
   assign rd_addr    = rd_idx_ff[IW-1:0];
   assign is_full    = (used_ff == USED_MAX);
   assign slot_found = (32'(req_ff.slot) < 32'(SLOTS)) &&
                       (32'(req_ff.slot) < 32'(used_ff)) && valid_ff[slot_idx];
   assign reg_ok     = cmd.exec && (req_ff.operation == OP_REGISTER) && !is_full;

   // Tick walk: read stage at rd_idx, evaluate stage at ev_idx
   assign rd_issue = (rd_idx_ff < used_ff);
   assign due      = ev_valid_ff && valid_ff[ev_idx_ff] && active_ff[ev_idx_ff] &&
                     ((req_ff.now - last_q_ff) >= period_q_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = cmd.walk_adv && due;

   assign stat.walk_done  = !rd_issue && !ev_valid_ff;
   assign stat.walk_stall = due && pend_valid_ff && !out_free;
   assign stat.out_free   = out_free;
   assign stat.pend_valid = pend_valid_ff;

   // Memory write ports
   always_comb begin
      per_we    = reg_ok || (cmd.exec && (req_ff.operation == OP_SET_INTERVAL) && slot_found);
      per_addr  = reg_ok ? new_idx : slot_idx;
      last_we   = 1'b0;
      last_addr = slot_idx;
      last_data = req_ff.now;
      if (fire) begin
         last_we   = 1'b1;
         last_addr = ev_idx_ff;
      end else if (reg_ok) begin
         last_we   = 1'b1;
         last_addr = new_idx;
         last_data = req_ff.start_time;
      end else if (cmd.exec && (req_ff.operation == OP_RESTART) && slot_found) begin
         last_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (per_we) begin
         period_mem_ff[per_addr] <= req_ff.period;
      end
      if (last_we) begin
         last_mem_ff[last_addr] <= last_data;
      end
      if (cmd.walk_adv && rd_issue) begin
         period_q_ff <= period_mem_ff[rd_addr];
         last_q_ff   <= last_mem_ff[rd_addr];
      end
   end

   // Result word selection and pending fired slot
   always_comb begin
      load          = 1'b0;
      rsp_in        = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      if (fire) begin
         if (pend_valid_ff) begin
            load   = 1'b1;
            rsp_in = '{result_slot: pend_slot_ff, fired: 1'b1, status: ST_OK, last: 1'b0};
         end
         pend_valid_in = 1'b1;
         pend_slot_in  = 3'(ev_idx_ff);
      end else if (cmd.flush_push) begin
         load          = 1'b1;
         rsp_in        = '{result_slot: pend_slot_ff, fired: 1'b1, status: ST_OK, last: 1'b1};
         pend_valid_in = 1'b0;
      end else if (cmd.exec) begin
         load = 1'b1;
         if (req_ff.operation == OP_REGISTER) begin
            rsp_in = '{result_slot: is_full ? 3'd0 : 3'(used_ff), fired: 1'b0,
                       status: is_full ? ST_FULL : ST_OK, last: 1'b1};
         end else begin
            rsp_in = '{result_slot: req_ff.slot, fired: 1'b0,
                       status: slot_found ? ST_OK : ST_NOT_FOUND, last: 1'b1};
         end
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
      pend_slot_ff <= pend_slot_in;
      if (cmd.walk_adv) begin
         ev_idx_ff <= rd_addr;
      end
   end

   // Control registers: flags, fill count, walk pipeline, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         active_ff     <= '0;
         used_ff       <= '0;
         rd_idx_ff     <= '0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (cmd.capture) begin
            rd_idx_ff   <= '0;
            ev_valid_ff <= 1'b0;
         end else if (cmd.walk_adv) begin
            ev_valid_ff <= rd_issue;
            if (rd_issue) begin
               rd_idx_ff <= rd_idx_ff + UW'(1);
            end
         end
         if (reg_ok) begin
            valid_ff[new_idx]  <= 1'b1;
            active_ff[new_idx] <= req_ff.start_enabled;
            used_ff            <= used_ff + UW'(1);
         end else if (cmd.exec && slot_found) begin
            unique case (req_ff.operation)
               OP_REMOVE: begin
                  valid_ff[slot_idx]  <= 1'b0;
                  active_ff[slot_idx] <= 1'b0;
               end
               OP_ENABLE: begin
                  active_ff[slot_idx] <= 1'b1;
               end
               OP_DISABLE: begin
                  active_ff[slot_idx] <= 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== src/periodic_timer_bank_top.sv =====
// Periodic timer bank. A non-tick word is captured, then executed once the
// result side is free, and its result word is registered; the unused code is
// dropped with no result word. The next word is taken once the bank is idle
// again. A tick walks the slots handed out so far through the period/last-fire
// memory read port, one slot a cycle unless a fired word is held by a stall.
// Synchronous active-high reset empties the bank; memory contents stay unset.
module periodic_timer_bank_top
   import ptb_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   cmd_type  cmd;
   stat_type stat;

   // Sequence each word
   ptb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req.operation),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold slot state and build result words
   ptb_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

// ===== src/ptb_checker.sv =====
// Port-level checks for the periodic timer bank, bound to the top level.
// Uses ptb_pkg and the macros of periodic_timer_bank_top_assert.svh.
`include "periodic_timer_bank_top_assert.svh"

module ptb_checker
   import ptb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   // Hold a stalled result word
   `PTB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
   // Fired words always carry ok status
   `PTB_ASSERT_IMPLIES(a_fired_ok, clock, reset, rsp_valid && rsp.fired, rsp.status == ST_OK)
   // Non-tick words are single and final
   `PTB_ASSERT_IMPLIES(a_single_last, clock, reset, rsp_valid && !rsp.fired, rsp.last)
   // Hold a stalled request word
   `PTB_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req))
   // Reset drops any result word
   `PTB_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind periodic_timer_bank_top ptb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for periodic_timer_bank_top: directed and random timer commands checked
// against a shadow copy of the slot table. Needs ptb_pkg and the block RTL.

import ptb_pkg::*;

// Shadow of the slot table plus the result words it predicts
class timer_bank_shadow;
   bit          live[SLOTS_DEFAULT];
   bit          running[SLOTS_DEFAULT];
   logic [31:0] interval[SLOTS_DEFAULT];
   logic [31:0] last_fire[SLOTS_DEFAULT];
   int unsigned handed_out;
   rsp_type     awaited[$];
   int unsigned mismatches;

   function void await_word(logic [2:0] slot, logic fired, logic [1:0] status, logic last);
      rsp_type r;
      r.result_slot = slot;
      r.fired       = fired;
      r.status      = status;
      r.last        = last;
      awaited.push_back(r);
   endfunction

   // Advance the table by one accepted command word
   function void take_word(req_type w);
      int          i;
      int unsigned due;
      logic [31:0] elapsed;
      due = 0;
      case (w.operation)
         OP_TICK: begin
            for (i = 0; i < SLOTS_DEFAULT && i < handed_out; i++) begin
               // elapsed time wraps modulo 2^32
               elapsed = w.now - last_fire[i];
               if (live[i] && running[i] && elapsed >= interval[i]) begin
                  last_fire[i] = w.now;
                  await_word(3'(i), 1'b1, ST_OK, 1'b0);
                  due++;
               end
            end
            // mark the final fired slot of this tick
            if (due > 0) awaited[awaited.size() - 1].last = 1'b1;
         end
         OP_REGISTER: begin
            if (handed_out >= SLOTS_DEFAULT) begin
               await_word(3'd0, 1'b0, ST_FULL, 1'b1);
            end else begin
               live[handed_out]      = 1'b1;
               running[handed_out]   = w.start_enabled;
               interval[handed_out]  = w.period;
               last_fire[handed_out] = w.start_time;
               await_word(3'(handed_out), 1'b0, ST_OK, 1'b1);
               handed_out++;
            end
         end
         OP_UNUSED: begin
            // dropped silently
         end
         default: begin
            // never handed out or removed: echo the slot, change nothing
            if (w.slot >= handed_out || !live[w.slot]) begin
               await_word(w.slot, 1'b0, ST_NOT_FOUND, 1'b1);
            end else begin
               case (w.operation)
                  OP_REMOVE: begin
                     live[w.slot]    = 1'b0;
                     running[w.slot] = 1'b0;
                  end
                  OP_ENABLE:       running[w.slot]   = 1'b1;
                  OP_DISABLE:      running[w.slot]   = 1'b0;
                  OP_SET_INTERVAL: interval[w.slot]  = w.period;
                  OP_RESTART:      last_fire[w.slot] = w.now;
                  default: begin
                  end
               endcase
               await_word(w.slot, 1'b0, ST_OK, 1'b1);
            end
         end
      endcase
   endfunction

   function void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
   endfunction

   // Compare one accepted result word with the oldest prediction
   function void match_word(rsp_type got);
      rsp_type want;
      if (awaited.size() == 0) begin
         mismatches++;
         $display("%0t: result expected none, got slot %0d fired %0b status %0d last %0b",
                  $time, got.result_slot, got.fired, got.status, got.last);
         return;
      end
      want = awaited.pop_front();
      if (got.result_slot !== want.result_slot)
         note_mismatch("result_slot", 32'(want.result_slot), 32'(got.result_slot));
      if (got.fired !== want.fired)
         note_mismatch("fired", 32'(want.fired), 32'(got.fired));
      if (got.status !== want.status)
         note_mismatch("status", 32'(want.status), 32'(got.status));
      if (got.last !== want.last)
         note_mismatch("last", 32'(want.last), 32'(got.last));
   endfunction
endclass

module testbench;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_WORDS = 360;
   localparam int unsigned DRAIN_CYCLES = 64;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   timer_bank_shadow shadow;
   logic [31:0]      wall_now    = 32'hFFFF_FC00;
   bit               steady      = 1'b0;
   int unsigned      cycle_count = 0;

   periodic_timer_bank_top #(.SLOTS(SLOTS_DEFAULT)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Stop a hung run
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   // Observe both handshakes at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) shadow.take_word(req);
         if (rsp_valid && !rsp_stall) shadow.match_word(rsp);
      end
   end

   // Stall the result side a random number of cycles per word
   initial begin
      int unsigned hold;
      @(posedge clock);
      forever begin
         hold = steady ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Offer one word after a random gap and hold it until taken
   task automatic send_word(input req_type w);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic issue(input logic [2:0] op, input logic [2:0] slot,
                        input logic [31:0] period, input logic [31:0] start,
                        input logic en, input logic [31:0] now);
      req_type w;
      w.operation     = op;
      w.slot          = slot;
      w.period        = period;
      w.start_time    = start;
      w.start_enabled = en;
      w.now           = now;
      send_word(w);
   endtask

   // Mostly slots already handed out, now and then any slot
   function automatic logic [2:0] pick_slot();
      if (shadow.handed_out > 0 && $urandom_range(0, 9) < 8)
         return 3'($urandom_range(0, shadow.handed_out - 1));
      return 3'($urandom_range(0, 7));
   endfunction

   // Short intervals so slots fire often, plus zero, fully random and near-maximum ones
   function automatic logic [31:0] pick_period();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return $urandom;
         2:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
         default: return 32'($urandom_range(0, 80));
      endcase
   endfunction

   // Build a command word: mostly well-formed, a few fully random
   function automatic req_type random_word();
      req_type     w;
      int unsigned pick;
      pick            = $urandom_range(0, 99);
      w.operation     = OP_TICK;
      w.slot          = 3'($urandom_range(0, 7));
      w.period        = $urandom;
      w.start_time    = $urandom;
      w.start_enabled = 1'($urandom_range(0, 1));
      w.now           = $urandom;
      if (pick < 5) begin
         w.operation = 3'($urandom_range(0, 7));
      end else if (pick < 50) begin
         // advance the wall time, wrapping past zero early in the run
         wall_now = wall_now + 32'($urandom_range(0, 40));
         w.now    = wall_now;
      end else if (pick < 57) begin
         w.operation = OP_REGISTER;
         w.period    = pick_period();
         if ($urandom_range(0, 4) != 0) w.start_time = wall_now - 32'($urandom_range(0, 60));
         w.start_enabled = ($urandom_range(0, 3) != 0);
      end else if (pick < 58) begin
         w.operation = OP_REMOVE;
         w.slot      = pick_slot();
      end else if (pick < 67) begin
         w.operation = OP_ENABLE;
         w.slot      = pick_slot();
      end else if (pick < 75) begin
         w.operation = OP_DISABLE;
         w.slot      = pick_slot();
      end else if (pick < 85) begin
         w.operation = OP_SET_INTERVAL;
         w.slot      = pick_slot();
         w.period    = pick_period();
      end else if (pick < 96) begin
         w.operation = OP_RESTART;
         w.slot      = pick_slot();
         w.now       = wall_now;
      end else begin
         w.operation = OP_UNUSED;
      end
      return w;
   endfunction

   initial begin
      req_type     w;
      int unsigned counted;
      shadow = new;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty bank, wrap-around, extreme intervals, missing slots
      issue(OP_TICK,         3'd0, 32'd0,         32'd0,         1'b0, 32'd0);
      issue(OP_ENABLE,       3'd0, 32'd0,         32'd0,         1'b0, 32'd0);
      issue(OP_REGISTER,     3'd7, 32'd0,         32'd0,         1'b1, 32'd0);
      issue(OP_REGISTER,     3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
      issue(OP_REGISTER,     3'd0, 32'd100,       32'hFFFF_FF80, 1'b1, 32'd0);
      issue(OP_TICK,         3'd0, 32'd0,         32'd0,         1'b0, 32'd0);
      issue(OP_TICK,         3'd0, 32'd0,         32'd0,         1'b0, 32'h10);
      issue(OP_ENABLE,       3'd1, 32'd0,         32'd0,         1'b0, 32'd0);
      issue(OP_TICK,         3'd0, 32'd0,         32'd0,         1'b0, 32'hFFFF_FFFE);
      issue(OP_TICK,         3'd0, 32'd0,         32'd0,         1'b0, 32'hFFFF_FFFE);
      issue(OP_DISABLE,      3'd0, 32'd0,         32'd0,         1'b0, 32'd0);
      issue(OP_TICK,         3'd0, 32'd0,         32'd0,         1'b0, 32'hFFFF_FFFE);
      issue(OP_SET_INTERVAL, 3'd2, 32'd5,         32'd0,         1'b0, 32'd0);
      issue(OP_RESTART,      3'd2, 32'd0,         32'd0,         1'b0, 32'h7FFF_FFFF);
      issue(OP_TICK,         3'd0, 32'd0,         32'd0,         1'b0, 32'h8000_0004);
      issue(OP_REMOVE,       3'd1, 32'd0,         32'd0,         1'b0, 32'd0);
      issue(OP_REMOVE,       3'd1, 32'd0,         32'd0,         1'b0, 32'd0);
      issue(OP_ENABLE,       3'd1, 32'd0,         32'd0,         1'b0, 32'd0);
      issue(OP_SET_INTERVAL, 3'd7, 32'd9,         32'd0,         1'b0, 32'd0);
      issue(OP_RESTART,      3'd3, 32'd0,         32'd0,         1'b0, 32'd0);
      issue(OP_DISABLE,      3'd6, 32'd0,         32'd0,         1'b0, 32'd0);
      issue(OP_UNUSED,       3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      issue(OP_ENABLE,       3'd0, 32'd0,         32'd0,         1'b0, 32'd0);
      issue(OP_TICK,         3'd0, 32'd0,         32'd0,         1'b0, 32'd0);

      // Random words; ignored codes do not count, one stretch runs without gaps
      counted = 0;
      while (counted < RANDOM_WORDS) begin
         steady = (counted >= 150 && counted < 230);
         w      = random_word();
         if (w.operation != OP_UNUSED) counted++;
         send_word(w);
      end
      steady = 1'b0;

      // Fill whatever is left of the table, then get one register refused
      while (shadow.handed_out < SLOTS_DEFAULT)
         issue(OP_REGISTER, 3'd0, pick_period(), wall_now, 1'b1, wall_now);
      issue(OP_REGISTER, 3'd0, 32'd1, 32'd0, 1'b1, 32'd0);
      req_valid <= 1'b0;

      // Drain predictions, then watch for stray words
      while (shadow.awaited.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (shadow.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ===== periodic_timer_bank_top.f =====
+incdir+src
src/ptb_pkg.sv
src/ptb_ctrl.sv
src/ptb_datapath.sv
src/periodic_timer_bank_top.sv
src/ptb_checker.sv
test/testbench.sv
